// File: rtl/des_pkg.sv
// Shared tables, types and bit permutation functions for the DES block cipher.
package des_pkg;

  localparam int unsigned BlockW  = 64;
  localparam int unsigned HalfW   = 32;
  localparam int unsigned KeyW    = 64;
  localparam int unsigned CdW     = 56;
  localparam int unsigned SubkeyW = 48;
  localparam int unsigned Rounds  = 16;
  localparam int unsigned RoundW  = $clog2(Rounds);

  // Sequencer state codes.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // Input kind codes.
  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  typedef struct packed {
    logic              cfg_we;
    logic              load;
    logic              step;
    logic              decrypt;
    logic [RoundW-1:0] round;
  } key_ctrl_t;

  localparam logic [6:0] IP_TBL [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [6:0] IPINV_TBL [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam logic [5:0] E_TBL [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
    6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
    6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
    6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
    6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] P_TBL [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [6:0] PC1_TBL [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TBL [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
    6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
    6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
    6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
    6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  localparam logic [1:0] ROT_TBL [16] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  // Indexed by box, then row * 16 + column.
  localparam logic [3:0] SBOX_TBL [8][64] = '{
    '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
      4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
      4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
      4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
    '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
      4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
      4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
      4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
    '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
      4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
      4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
      4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
    '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
      4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
      4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
      4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
    '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
      4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
      4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
      4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
    '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
      4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
      4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
      4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
    '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
      4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
      4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
      4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
    '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
      4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
      4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
      4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
  };

  // Table entries count bit positions from the MSB, starting at one.
  function automatic logic [BlockW-1:0] perm_ip(input logic [BlockW-1:0] v);
    logic [BlockW-1:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64 - int'(IP_TBL[i])];
    return r;
  endfunction

  function automatic logic [BlockW-1:0] perm_ipinv(input logic [BlockW-1:0] v);
    logic [BlockW-1:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64 - int'(IPINV_TBL[i])];
    return r;
  endfunction

  function automatic logic [SubkeyW-1:0] perm_e(input logic [HalfW-1:0] v);
    logic [SubkeyW-1:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = v[32 - int'(E_TBL[i])];
    return r;
  endfunction

  function automatic logic [HalfW-1:0] perm_p(input logic [HalfW-1:0] v);
    logic [HalfW-1:0] r;
    for (int i = 0; i < 32; i++) r[31-i] = v[32 - int'(P_TBL[i])];
    return r;
  endfunction

  function automatic logic [CdW-1:0] perm_pc1(input logic [KeyW-1:0] v);
    logic [CdW-1:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = v[64 - int'(PC1_TBL[i])];
    return r;
  endfunction

  function automatic logic [SubkeyW-1:0] perm_pc2(input logic [CdW-1:0] v);
    logic [SubkeyW-1:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = v[56 - int'(PC2_TBL[i])];
    return r;
  endfunction

  function automatic logic [27:0] rotl28(input logic [27:0] v, input logic [1:0] s);
    logic [27:0] r;
    r = (s == 2'd2) ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
    return r;
  endfunction

  function automatic logic [27:0] rotr28(input logic [27:0] v, input logic [1:0] s);
    logic [27:0] r;
    r = (s == 2'd2) ? {v[1:0], v[27:2]} : {v[0], v[27:1]};
    return r;
  endfunction

endpackage

// File: rtl/des_key_sched.sv
// Key register and on-the-fly round subkey generator (PC-1, rotations, PC-2).
module des_key_sched (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  des_pkg::key_ctrl_t           ctrl_i,
  input  logic [des_pkg::KeyW-1:0]     cipher_key_i,
  output logic [des_pkg::SubkeyW-1:0]  subkey_o
);

  logic [des_pkg::KeyW-1:0] key_q;
  logic [des_pkg::CdW-1:0]  cd_q, cd_d, cd_rotl;

  // Encryption rotates left before each round. Decryption starts from the
  // unrotated halves, which equal the last round's halves, and rotates right.
  always_comb begin
    cd_rotl = {des_pkg::rotl28(cd_q[55:28], des_pkg::ROT_TBL[ctrl_i.round]),
               des_pkg::rotl28(cd_q[27:0],  des_pkg::ROT_TBL[ctrl_i.round])};
    if (ctrl_i.decrypt) begin
      subkey_o = des_pkg::perm_pc2(cd_q);
      cd_d = {des_pkg::rotr28(cd_q[55:28], des_pkg::ROT_TBL[~ctrl_i.round]),
              des_pkg::rotr28(cd_q[27:0],  des_pkg::ROT_TBL[~ctrl_i.round])};
    end else begin
      subkey_o = des_pkg::perm_pc2(cd_rotl);
      cd_d     = cd_rotl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (ctrl_i.cfg_we) begin
      key_q <= cipher_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cd_q <= des_pkg::perm_pc1(key_q);
    end else if (ctrl_i.step) begin
      cd_q <= cd_d;
    end
  end

endmodule

// File: rtl/des_round.sv
// One Feistel round: expansion, subkey mix, S-boxes and P permutation.
module des_round (
  input  logic [des_pkg::HalfW-1:0]   l_i,
  input  logic [des_pkg::HalfW-1:0]   r_i,
  input  logic [des_pkg::SubkeyW-1:0] subkey_i,
  output logic [des_pkg::HalfW-1:0]   l_o,
  output logic [des_pkg::HalfW-1:0]   r_o
);

  logic [des_pkg::SubkeyW-1:0] mixed;
  logic [des_pkg::HalfW-1:0]   s_out;
  logic [5:0]                  six;

  always_comb begin
    mixed = des_pkg::perm_e(r_i) ^ subkey_i;
    s_out = '0;
    six   = '0;
    for (int n = 0; n < 8; n++) begin
      six = mixed[47 - 6*n -: 6];
      // Outer bits pick the row, inner four bits the column.
      s_out[31 - 4*n -: 4] = des_pkg::SBOX_TBL[n][{six[5], six[0], six[4:1]}];
    end
    l_o = r_i;
    r_o = l_i ^ des_pkg::perm_p(s_out);
  end

endmodule

// File: rtl/des_block_cipher.sv
// DES block cipher top level: round sequencer, half-block registers and ports.
// A taken request yields done_o, one cycle wide, once the last round is done.
// A new block is taken only once the previous one is finished; the shared round unit runs once per cycle while busy.
// busy is high from the accepting edge until the result strobe; cfg_ready_o is its inverse.
// Reset clears the key to zero and returns the sequencer to idle; the result cannot stall.
module des_block_cipher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        kind_i,
  input  logic [des_pkg::BlockW-1:0]  data_block_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [des_pkg::KeyW-1:0]    cipher_key_i,
  output logic                        done_o,
  output logic [des_pkg::BlockW-1:0]  result_block_o
);

  logic                          state_q, state_d;
  logic [des_pkg::RoundW-1:0]    rnd_q;
  logic                          dec_q;
  logic                          done_q;
  logic [des_pkg::HalfW-1:0]     l_q, r_q, l_nxt, r_nxt;
  logic [des_pkg::BlockW-1:0]    ip_out, res_q;
  logic [des_pkg::SubkeyW-1:0]   subkey;
  logic                          accept, last;
  des_pkg::key_ctrl_t            kctrl;

  assign accept      = start && (state_q == des_pkg::ST_IDLE);
  assign last        = (state_q == des_pkg::ST_RUN) &&
                       (rnd_q == des_pkg::RoundW'(des_pkg::Rounds - 1));
  assign busy        = (state_q == des_pkg::ST_RUN);
  assign cfg_ready_o = (state_q == des_pkg::ST_IDLE);
  assign ip_out      = des_pkg::perm_ip(data_block_i);

  always_comb begin
    kctrl.cfg_we  = cfg_valid_i && cfg_ready_o;
    kctrl.load    = accept;
    kctrl.step    = (state_q == des_pkg::ST_RUN);
    kctrl.decrypt = (dec_q == des_pkg::KIND_DECRYPT);
    kctrl.round   = rnd_q;
  end

  always_comb begin
    unique case (state_q)
      des_pkg::ST_IDLE: state_d = accept ? des_pkg::ST_RUN : des_pkg::ST_IDLE;
      des_pkg::ST_RUN:  state_d = last ? des_pkg::ST_IDLE : des_pkg::ST_RUN;
      default:          state_d = des_pkg::ST_IDLE;
    endcase
  end

  des_key_sched u_key_sched (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (kctrl),
    .cipher_key_i (cipher_key_i),
    .subkey_o     (subkey)
  );

  des_round u_round (
    .l_i      (l_q),
    .r_i      (r_q),
    .subkey_i (subkey),
    .l_o      (l_nxt),
    .r_o      (r_nxt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= des_pkg::ST_IDLE;
      rnd_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= last;
      if (accept) begin
        rnd_q <= '0;
      end else if (state_q == des_pkg::ST_RUN) begin
        rnd_q <= rnd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dec_q <= kind_i;
      l_q   <= ip_out[63:32];
      r_q   <= ip_out[31:0];
    end else if (state_q == des_pkg::ST_RUN) begin
      l_q <= l_nxt;
      r_q <= r_nxt;
    end
    // The halves are swapped back before the final permutation.
    if (last) begin
      res_q <= des_pkg::perm_ipinv({r_nxt, l_nxt});
    end
  end

  assign done_o         = done_q;
  assign result_block_o = res_q;

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == des_pkg::ST_RUN) &&
               $past(rnd_q) == des_pkg::RoundW'(des_pkg::Rounds - 1))
    else $error("result strobe without a finished last round");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && rnd_q == '0)
    else $error("accepted request did not start at round zero");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last |=> !busy && done_o)
    else $error("last round did not return to idle with a strobe");

  a_no_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !kctrl.cfg_we && !kctrl.load)
    else $error("key write or reload while a block is in flight");

endmodule
